[rtl/smc_pkg.sv]
package smc_pkg;

  // Register reset values
  localparam logic [15:0] TICK_PERIOD_RST = 16'd8000;
  localparam logic [15:0] STEP_COUNT_RST  = 16'd1000;

  // Register indexes on the configuration port
  localparam logic REG_TICK_PERIOD = 1'b0;
  localparam logic REG_STEP_COUNT  = 1'b1;

  // One-hot move codes
  localparam logic [7:0] DIR_N  = 8'h01;
  localparam logic [7:0] DIR_E  = 8'h02;
  localparam logic [7:0] DIR_S  = 8'h04;
  localparam logic [7:0] DIR_W  = 8'h08;
  localparam logic [7:0] DIR_NE = 8'h10;
  localparam logic [7:0] DIR_SE = 8'h20;
  localparam logic [7:0] DIR_SW = 8'h40;
  localparam logic [7:0] DIR_NW = 8'h80;

  // Wheel control bit positions
  localparam int EN1_IDX  = 0;
  localparam int DIR1_IDX = 1;
  localparam int EN2_IDX  = 2;
  localparam int DIR2_IDX = 3;
  localparam logic [3:0] EN_MASK = 4'b0101;

  typedef struct packed {
    logic [15:0] tick_period;
    logic [15:0] step_count;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] wheel;
  } dir_dec_t;

  typedef struct packed {
    logic [3:0] phase_bits;
    logic       enable_first;
    logic       dir_first;
    logic       enable_second;
    logic       dir_second;
    logic       busy_res;
    logic       move_done;
  } result_t;

  // Half-step coil sequence
  function automatic logic [3:0] coil_of(input logic [2:0] idx);
    logic [3:0] c;
    unique case (idx)
      3'd0: c = 4'd8;
      3'd1: c = 4'd9;
      3'd2: c = 4'd1;
      3'd3: c = 4'd5;
      3'd4: c = 4'd4;
      3'd5: c = 4'd6;
      3'd6: c = 4'd2;
      default: c = 4'd10;
    endcase
    return c;
  endfunction

  // Map a move code onto the wheel controls; ok drops for unknown codes
  function automatic dir_dec_t decode_dir(input logic [3:0] wheel, input logic [7:0] code);
    dir_dec_t d;
    d.ok    = 1'b1;
    d.wheel = wheel;
    unique case (code)
      DIR_N:   d.wheel = 4'b1111;
      DIR_E:   d.wheel = 4'b1101;
      DIR_S:   d.wheel = 4'b0101;
      DIR_W:   d.wheel = 4'b0111;
      DIR_NE:  d.wheel = wheel | 4'b1100;
      DIR_SE:  d.wheel = (wheel | 4'b0001) & 4'b1101;
      DIR_SW:  d.wheel = (wheel | 4'b0100) & 4'b0111;
      DIR_NW:  d.wheel = wheel | 4'b0011;
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

[rtl/smc_cfg.sv]
module smc_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output smc_pkg::cfg_t      cfg
);

  logic [15:0] tick_period_r;
  logic [15:0] step_count_r;
  logic        wr_en;
  logic        reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Write registers in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= smc_pkg::TICK_PERIOD_RST;
      step_count_r  <= smc_pkg::STEP_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        smc_pkg::REG_TICK_PERIOD: tick_period_r <= pwdata[15:0];
        default:                  step_count_r  <= pwdata[15:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      smc_pkg::REG_TICK_PERIOD: prdata = {16'd0, tick_period_r};
      default:                  prdata = {16'd0, step_count_r};
    endcase
  end

  assign cfg.tick_period = tick_period_r;
  assign cfg.step_count  = step_count_r;

endmodule

[rtl/smc_core.sv]
module smc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic               req_type,
  input  logic [7:0]         direction,
  input  smc_pkg::cfg_t      cfg,
  output smc_pkg::result_t   res_nxt
);

  logic [15:0] timer_r, timer_nxt;
  logic [15:0] steps_r, steps_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  coil_r, coil_nxt;
  logic [3:0]  wheel_r, wheel_nxt;
  logic        moving_r, moving_nxt;
  logic        done;
  logic [15:0] steps_inc;
  smc_pkg::dir_dec_t dec;

  assign steps_inc = steps_r + 16'd1;
  assign dec       = smc_pkg::decode_dir(wheel_r, direction);

  // Next state for one clock beat
  always_comb begin
    timer_nxt  = timer_r;
    steps_nxt  = steps_r;
    phase_nxt  = phase_r;
    coil_nxt   = coil_r;
    wheel_nxt  = wheel_r;
    moving_nxt = moving_r;
    done       = 1'b0;
    priority if (moving_r) begin
      if (timer_r == cfg.tick_period) begin
        // Tick: advance the coil pattern, drop enables at the last step
        timer_nxt = 16'd0;
        coil_nxt  = smc_pkg::coil_of(phase_r);
        phase_nxt = phase_r + 3'd1;
        steps_nxt = steps_inc;
        if (steps_inc >= cfg.step_count) begin
          moving_nxt = 1'b0;
          wheel_nxt  = wheel_r & ~smc_pkg::EN_MASK;
          done       = 1'b1;
        end
      end else begin
        timer_nxt = timer_r + 16'd1;
      end
    end else if (req_type && dec.ok) begin
      // Start a move from the first phase, or finish at once if step_count is 0
      timer_nxt = 16'd0;
      steps_nxt = 16'd0;
      phase_nxt = 3'd0;
      if (cfg.step_count == 16'd0) begin
        wheel_nxt = dec.wheel & ~smc_pkg::EN_MASK;
        done      = 1'b1;
      end else begin
        wheel_nxt  = dec.wheel;
        moving_nxt = 1'b1;
      end
    end else begin
      // Hold: idle with no usable move command
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= 16'd0;
      steps_r  <= 16'd0;
      phase_r  <= 3'd0;
      coil_r   <= 4'd0;
      wheel_r  <= 4'd0;
      moving_r <= 1'b0;
    end else if (acc) begin
      timer_r  <= timer_nxt;
      steps_r  <= steps_nxt;
      phase_r  <= phase_nxt;
      coil_r   <= coil_nxt;
      wheel_r  <= wheel_nxt;
      moving_r <= moving_nxt;
    end
  end

  assign res_nxt.phase_bits    = coil_nxt;
  assign res_nxt.enable_first  = wheel_nxt[smc_pkg::EN1_IDX];
  assign res_nxt.dir_first     = wheel_nxt[smc_pkg::DIR1_IDX];
  assign res_nxt.enable_second = wheel_nxt[smc_pkg::EN2_IDX];
  assign res_nxt.dir_second    = wheel_nxt[smc_pkg::DIR2_IDX];
  assign res_nxt.busy_res      = moving_nxt;
  assign res_nxt.move_done     = done;

endmodule

[rtl/stepper_half_step_move_controller.sv]
// Half-step stepper move controller.
// Input channel (in_valid/in_ready): one beat per controller clock when
// in_ready is high; a beat with in_req_type set carries a one-hot move
// code in in_direction, which starts a move only while no move is running.
// Result channel (out_valid/out_ready): one beat per input beat, showing
// the coil pattern, wheel enables and directions, busy flag and done pulse
// after that input beat.
// The result of a beat is registered; it is valid the cycle after acceptance.
// Throughput: one beat per cycle; the single step logic sits between the
// state and result registers, so only out_ready low on a held result stalls it.
// Stall: in_ready follows out_ready while a result is held; a new beat is
// taken in the same cycle the held result leaves.
// Reset (rst_n low, synchronous): coils off, enables and directions low in
// the core state, idle, tick_period 8000 and step_count 1000.
// Config: APB writes at 0x0 (tick_period) and 0x4 (step_count), to be made
// while idle; pready is tied high.
module stepper_half_step_move_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_direction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_phase_bits,
  output logic        out_enable_first,
  output logic        out_dir_first,
  output logic        out_enable_second,
  output logic        out_dir_second,
  output logic        out_busy_res,
  output logic        out_move_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  smc_pkg::cfg_t    cfg;
  smc_pkg::result_t res_nxt;
  smc_pkg::result_t res_r;
  logic             out_valid_r;
  logic             acc;

  assign pready   = 1'b1;
  assign in_ready = ~out_valid_r | out_ready;
  assign acc      = in_valid & in_ready;

  smc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  smc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req_type  (in_req_type),
    .direction (in_direction),
    .cfg       (cfg),
    .res_nxt   (res_nxt)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_phase_bits    = res_r.phase_bits;
  assign out_enable_first  = res_r.enable_first;
  assign out_dir_first     = res_r.dir_first;
  assign out_enable_second = res_r.enable_second;
  assign out_dir_second    = res_r.dir_second;
  assign out_busy_res      = res_r.busy_res;
  assign out_move_done     = res_r.move_done;

endmodule

[rtl/smc_checker.sv]
module smc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_phase_bits,
  input logic       out_enable_first,
  input logic       out_enable_second,
  input logic       out_busy_res,
  input logic       out_move_done
);

  // A finished move shows both enables dropped and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_enable_first && !out_enable_second && !out_busy_res)
    else $error("move_done with enables or busy still set");

  // A running move always drives at least one wheel pair
  a_busy_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busy_res |-> out_enable_first || out_enable_second)
    else $error("busy with both enables low");

  // An empty result slot never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase_bits)
      && $stable(out_busy_res) && $stable(out_move_done))
    else $error("stalled result beat changed");

endmodule

bind stepper_half_step_move_controller smc_checker u_smc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_phase_bits    (out_phase_bits),
  .out_enable_first  (out_enable_first),
  .out_enable_second (out_enable_second),
  .out_busy_res      (out_busy_res),
  .out_move_done     (out_move_done)
);
